### hdl/spt_pkg.sv
// spectrum peak tracker package: payload structs, fixed-point constants, helpers
// no dependencies; imported by every module of the block
package spt_pkg;

  typedef struct packed {
    logic [15:0] magnitude;
    logic        last_bin;
  } bin_item_t;

  typedef struct packed {
    logic [15:0] bin_peak;
    logic        frame_done;
    logic [5:0]  peak_index;
    logic [5:0]  lazy_index;
    logic [15:0] peak_value;
    logic [15:0] floating_average;
    logic [15:0] floating_average_min;
  } res_item_t;

  // per-item info handed from the bin stage to the summary pipeline
  typedef struct packed {
    logic        last;
    logic [15:0] bin_peak;
    logic [15:0] best_raw;
  } bin_info_t;

  localparam logic [15:0] DECAY_KEEP = 16'd64684;
  localparam logic [15:0] DECAY_ADD  = 16'd1049;
  localparam logic [15:0] AVG_KEEP   = 16'd64881;
  localparam logic [15:0] AVG_ADD    = 16'd1442;

  localparam int FLOOR_NUM_MUL = 19;
  localparam int FLOOR_IDX_MUL = 14;
  localparam int FLOOR_DEN_MUL = 10;

  // reciprocal constants for small divides by 5 and 3
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = 3;

  localparam int          PADDR_W             = 3;
  localparam logic        CFG_AVG_MIN_SCALE   = 1'b0;
  localparam logic [15:0] AVG_MIN_SCALE_RESET = 16'd100;

  function automatic logic [15:0] sat16(input logic [39:0] v);
    return (v > 40'h0_0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

### hdl/spectrum_peak_tracker_top.sv
// spectrum peak tracker top level: config register, credit control, result fifo
// depends on spt_pkg, spt_bin_stage, spt_summary
//
// bins stream in on bin_valid/bin_item, one magnitude per item in bin order;
// last_bin marks the end of a frame. every item yields one result item on
// res_valid/res_item: the bin's updated decaying peak, plus the frame summary
// (peak bin, lazy index, peak value, floating average and its floor) on the
// last bin of a frame, with the summary fields zero on other bins.
// an accepted item passes the bin stage, summary stages b and c and the fifo;
// one item per cycle is taken and delivered when the receiver does not stall.
// the peak memory is read one bin ahead so each item is a single pass; the
// floor divide runs as a two stage multiply pipeline.
// results land in an 8-entry fifo; bin_stall rises when 8 items are in
// flight or waiting, so a stalled receiver backs up into the input after
// that. reset clears all per-bin peaks (by fill count), the tracker state and
// the fifo, and loads avg_min_scale with 100. the user writes avg_min_scale
// via the apb port at byte address 0 while the block is idle (not enforced).
module spectrum_peak_tracker_top #(
  parameter int NUM_BINS    = 64,
  parameter int SEARCH_BINS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  spt_pkg::bin_item_t            bin_item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output spt_pkg::res_item_t            res_item
);
  import spt_pkg::*;

  localparam int IW = $clog2(NUM_BINS);

  logic [15:0]        avg_min_scale;
  logic               cfg_hit;
  logic               bin_accept, res_fire;
  logic [FIFO_PW:0]   credit;
  logic [FIFO_PW:0]   wr_ptr, rd_ptr;
  res_item_t          fifo_mem [FIFO_DEPTH];

  logic               a_valid;
  bin_info_t          a_info;
  logic [IW-1:0]      a_best_index;
  logic               s_valid;
  res_item_t          s_item;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == CFG_AVG_MIN_SCALE);
  assign prdata  = cfg_hit ? {16'd0, avg_min_scale} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_min_scale <= AVG_MIN_SCALE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      avg_min_scale <= pwdata[15:0];
    end
  end

  assign bin_stall  = (credit == (FIFO_PW+1)'(FIFO_DEPTH));
  assign bin_accept = bin_valid && !bin_stall;
  assign res_valid  = (wr_ptr != rd_ptr);
  assign res_fire   = res_valid && !res_stall;
  assign res_item   = fifo_mem[rd_ptr[FIFO_PW-1:0]];

  spt_bin_stage #(
    .NUM_BINS    (NUM_BINS),
    .SEARCH_BINS (SEARCH_BINS)
  ) u_bin_stage (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (bin_accept),
    .in_item        (bin_item),
    .out_valid      (a_valid),
    .out_info       (a_info),
    .out_best_index (a_best_index)
  );

  spt_summary #(
    .NUM_BINS    (NUM_BINS),
    .SEARCH_BINS (SEARCH_BINS)
  ) u_summary (
    .clk           (clk),
    .rst           (rst),
    .avg_min_scale (avg_min_scale),
    .in_valid      (a_valid),
    .in_info       (a_info),
    .in_best_index (a_best_index),
    .out_valid     (s_valid),
    .out_item      (s_item)
  );

  always_ff @(posedge clk) begin
    if (s_valid) begin
      fifo_mem[wr_ptr[FIFO_PW-1:0]] <= s_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      case ({bin_accept, res_fire})
        2'b10:   credit <= credit + 1'b1;
        2'b01:   credit <= credit - 1'b1;
        default: credit <= credit;
      endcase
      if (s_valid) wr_ptr <= wr_ptr + 1'b1;
      if (res_fire) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

### hdl/spt_bin_stage.sv
// spectrum peak tracker bin stage: per-bin peak memory, decay update, first-max search
// depends on spt_pkg
module spt_bin_stage #(
  parameter int NUM_BINS    = 64,
  parameter int SEARCH_BINS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  spt_pkg::bin_item_t            in_item,
  output logic                          out_valid,
  output spt_pkg::bin_info_t            out_info,
  output logic [$clog2(NUM_BINS)-1:0]   out_best_index
);
  import spt_pkg::*;

  localparam int IW = $clog2(NUM_BINS);
  localparam int FW = $clog2(NUM_BINS + 1);

  logic [15:0]   mem [NUM_BINS];
  logic [IW-1:0] bin_counter, bin_counter_next;
  logic [FW-1:0] fill, fill_next;
  logic [15:0]   rd_data, fwd_data;
  logic          fwd_sel, rd_zero;
  logic [IW-1:0] best_index, best_index_next;
  logic [15:0]   best_peak, best_peak_next;
  logic [15:0]   best_raw, best_raw_next;
  logic [15:0]   pk_old, pk_new;
  logic [32:0]   decay_sum;
  logic          in_search;

  always_comb begin
    pk_old    = rd_zero ? 16'd0 : (fwd_sel ? fwd_data : rd_data);
    decay_sum = 33'(pk_old) * 33'(DECAY_KEEP) + 33'(in_item.magnitude) * 33'(DECAY_ADD);
    pk_new    = (in_item.magnitude > pk_old) ? in_item.magnitude
                                             : sat16(40'(decay_sum >> 16));
    in_search = (32'(bin_counter) < 32'(SEARCH_BINS));

    best_index_next = best_index;
    best_peak_next  = best_peak;
    best_raw_next   = best_raw;
    if (bin_counter == '0) begin
      best_index_next = '0;
      best_peak_next  = pk_new;
      best_raw_next   = in_item.magnitude;
    end else if (in_search && (pk_new > best_peak)) begin
      best_index_next = bin_counter;
      best_peak_next  = pk_new;
      best_raw_next   = in_item.magnitude;
    end

    if (in_item.last_bin || (bin_counter == IW'(NUM_BINS - 1))) begin
      bin_counter_next = '0;
    end else begin
      bin_counter_next = bin_counter + 1'b1;
    end

    // entries are first reached in ascending order, so a count marks what is written
    fill_next = (FW'(bin_counter) == fill) ? fill + 1'b1 : fill;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mem[bin_counter]        <= pk_new;
      rd_data                 <= mem[bin_counter_next];
      fwd_data                <= pk_new;
      out_info.last           <= in_item.last_bin;
      out_info.bin_peak       <= pk_new;
      out_info.best_raw       <= best_raw_next;
      out_best_index          <= best_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      fill        <= '0;
      rd_zero     <= 1'b1;
      fwd_sel     <= 1'b0;
      best_index  <= '0;
      best_peak   <= '0;
      best_raw    <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid) begin
        bin_counter <= bin_counter_next;
        fill        <= fill_next;
        fwd_sel     <= (bin_counter_next == bin_counter);
        rd_zero     <= (FW'(bin_counter_next) >= fill_next);
        best_index  <= best_index_next;
        best_peak   <= best_peak_next;
        best_raw    <= best_raw_next;
      end
    end
  end

endmodule

### hdl/spt_summary.sv
// spectrum peak tracker summary pipeline: floor divide, index tracker, floating average
// depends on spt_pkg; fed by spt_bin_stage
module spt_summary #(
  parameter int NUM_BINS    = 64,
  parameter int SEARCH_BINS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [15:0]                   avg_min_scale,
  input  logic                          in_valid,
  input  spt_pkg::bin_info_t            in_info,
  input  logic [$clog2(NUM_BINS)-1:0]   in_best_index,
  output logic                          out_valid,
  output spt_pkg::res_item_t            out_item
);
  import spt_pkg::*;

  localparam int IW    = $clog2(NUM_BINS);
  localparam int TW    = $clog2(SEARCH_BINS + 1);
  localparam int DW    = ((IW > TW) ? IW : TW) + 2;
  localparam int NUMW  = $clog2(FLOOR_NUM_MUL * NUM_BINS + 1);
  localparam int PRODW = 16 + NUMW;
  localparam int DEN   = FLOOR_DEN_MUL * NUM_BINS;
  localparam int DENL  = $clog2(DEN);
  localparam int SHIFT = PRODW + DENL;
  localparam int RECW  = PRODW + 1;
  localparam int QW    = PRODW - DENL + 1;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);

  // stage b
  logic             b_valid;
  bin_info_t        b_info;
  logic [IW-1:0]    b_bi;
  logic [PRODW-1:0] b_prod;
  logic [NUMW-1:0]  num;

  // stage c
  logic             c_valid;
  bin_info_t        c_info;
  logic [IW-1:0]    c_bi;
  logic [QW-1:0]    c_quot;
  logic [2*PRODW:0] recip_prod;

  // frame state
  logic [TW-1:0]    tracked, tracked_next;
  logic [IW-1:0]    lazy, lazy_next;
  logic [15:0]      smoothed, smoothed_next;

  logic signed [DW-1:0] d, d2;
  logic [DW-1:0]        dmag, mv5, mv3;
  logic [DW+15:0]       p5, p3;
  logic [DW:0]          up_sum;
  logic [33:0]          t_sum;
  logic [15:0]          fmin, t_avg;
  logic                 close;

  assign num = NUMW'(FLOOR_NUM_MUL * NUM_BINS)
             - NUMW'(NUMW'(FLOOR_IDX_MUL) * NUMW'(in_best_index));
  assign recip_prod = (2*PRODW+1)'(b_prod) * (2*PRODW+1)'(RECIP[RECW-1:0]);

  always_ff @(posedge clk) begin
    b_info <= in_info;
    b_bi   <= in_best_index;
    b_prod <= PRODW'(avg_min_scale) * PRODW'(num);
    c_info <= b_info;
    c_bi   <= b_bi;
    c_quot <= recip_prod[SHIFT +: QW];
  end

  always_comb begin
    fmin = sat16(40'(c_quot));

    d    = $signed(DW'(c_bi)) - $signed(DW'(tracked));
    dmag = d[DW-1] ? DW'(-d) : DW'(d);
    p5   = (DW+16)'(dmag) * (DW+16)'(DIV5_MUL);
    p3   = (DW+16)'(dmag) * (DW+16)'(DIV3_MUL);
    mv5  = DW'(p5 >> DIV5_SHIFT);
    mv3  = DW'(p3 >> DIV3_SHIFT);
    if (mv5 == '0) mv5 = DW'(1);
    if (mv3 == '0) mv3 = DW'(1);
    up_sum = (DW+1)'(tracked) + (DW+1)'(mv5);

    if (d > 0) begin
      tracked_next = (up_sum > (DW+1)'(SEARCH_BINS)) ? TW'(SEARCH_BINS) : TW'(up_sum);
    end else if (d < 0) begin
      tracked_next = (DW'(tracked) > mv3) ? TW'(DW'(tracked) - mv3) : '0;
    end else begin
      tracked_next = tracked;
    end

    d2        = $signed(DW'(c_bi)) - $signed(DW'(tracked_next));
    close     = (d2 < 3) && (d2 > -3);
    lazy_next = close ? c_bi : lazy;

    t_sum = 34'(smoothed) * 34'(AVG_KEEP) + 34'(c_info.best_raw) * 34'(AVG_ADD);
    t_avg = sat16(40'(t_sum >> 16));
    smoothed_next = c_info.best_raw;
    if (fmin > smoothed_next)  smoothed_next = fmin;
    if (t_avg > smoothed_next) smoothed_next = t_avg;

    out_valid         = c_valid;
    out_item          = '0;
    out_item.bin_peak = c_info.bin_peak;
    if (c_info.last) begin
      out_item.frame_done           = 1'b1;
      out_item.peak_index           = 6'(c_bi);
      out_item.lazy_index           = 6'(lazy_next);
      out_item.peak_value           = c_info.best_raw;
      out_item.floating_average     = smoothed_next;
      out_item.floating_average_min = fmin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      tracked  <= '0;
      lazy     <= '0;
      smoothed <= '0;
    end else begin
      b_valid <= in_valid;
      c_valid <= b_valid;
      if (c_valid && c_info.last) begin
        tracked  <= tracked_next;
        lazy     <= lazy_next;
        smoothed <= smoothed_next;
      end
    end
  end

endmodule

### hdl/spt_checker.sv
// spectrum peak tracker port checker and its bind to the top level
// depends on spt_pkg and spectrum_peak_tracker_top
module spt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_stall,
  input spt_pkg::res_item_t            res_item
);
  import spt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_item))
    else $error("result changed while stalled");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.frame_done |->
      res_item.peak_index == 6'd0 && res_item.lazy_index == 6'd0 &&
      res_item.peak_value == 16'd0 && res_item.floating_average == 16'd0 &&
      res_item.floating_average_min == 16'd0)
    else $error("summary fields set on a non-final bin");

  a_avg_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.frame_done |->
      res_item.floating_average >= res_item.peak_value &&
      res_item.floating_average >= res_item.floating_average_min)
    else $error("floating average below its floor");

endmodule

bind spectrum_peak_tracker_top spt_checker u_spt_checker (.*);
